FILE: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int MAX_FRAMES_DEF  = 32768;
	localparam int FRAME_SHIFT_DEF = 12;
	localparam int ADDR_W          = 27;
	localparam int OP_W            = 2;
	localparam int STAT_W          = 2;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [CFG_W-1:0] TOTAL_RST    = 16'd32768;
	localparam logic [CFG_W-1:0] RESERVED_RST = 16'd256;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_INIT,
		CMD_ALLOC,
		CMD_FREE,
		CMD_RANGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_INIT,
		B_ALLOC,
		B_FREE_RD,
		B_FREE_WR
	} back_state_t;

	// width for frame counts and compares, with one spare bit of headroom
	function automatic int cnt_w(input int max_frames);
		int t;
		t = $clog2(max_frames + 1);
		return ((t > CFG_W) ? t : CFG_W) + 1;
	endfunction

	function automatic int word_aw(input int max_frames);
		int wc;
		wc = (max_frames + 31) / 32;
		return (wc > 1) ? $clog2(wc) : 1;
	endfunction

endpackage

FILE: rtl/core/bfa_queue.sv
`timescale 1ns / 1ps

module bfa_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  bfa_pkg::cmd_t           din,
	input  logic                    pop,
	output bfa_pkg::cmd_t           dout,
	output bfa_pkg::queue_status_t  qstat
);

	localparam int DEPTH = bfa_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	bfa_pkg::cmd_t   entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.valid = (count_q != '0);
	assign qstat.full  = (count_q == CNTW'(DEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && qstat.valid;
	assign dout        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

FILE: rtl/core/bfa_front.sv
`timescale 1ns / 1ps

module bfa_front #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF
) (
	input  logic                                  start,
	output logic                                  busy,
	input  logic [bfa_pkg::OP_W-1:0]              opcode,
	input  logic [bfa_pkg::ADDR_W-1:0]            free_address,
	input  logic [bfa_pkg::cnt_w(MAX_FRAMES)-1:0] eff_total,
	input  bfa_pkg::queue_status_t                qstat,
	input  bfa_pkg::back_status_t                 bstat,
	output logic                                  q_push,
	output bfa_pkg::cmd_t                         q_cmd
);

	localparam int CW = bfa_pkg::cnt_w(MAX_FRAMES);
	localparam int XW = CW + bfa_pkg::ADDR_W;

	logic [bfa_pkg::ADDR_W-1:0] page_num;
	logic                       out_range;

	assign busy   = qstat.full || bstat.clearing;
	assign q_push = start && !busy;

	assign page_num  = free_address >> FRAME_SHIFT;
	assign out_range = XW'(page_num) >= XW'(eff_total);

	always_comb begin
		q_cmd.addr = free_address;
		unique case (opcode)
			bfa_pkg::OP_INIT:  q_cmd.kind = bfa_pkg::CMD_INIT;
			bfa_pkg::OP_ALLOC: q_cmd.kind = bfa_pkg::CMD_ALLOC;
			bfa_pkg::OP_FREE:  q_cmd.kind = out_range ? bfa_pkg::CMD_RANGE : bfa_pkg::CMD_FREE;
			default:           q_cmd.kind = bfa_pkg::CMD_NOP;
		endcase
	end

endmodule

FILE: rtl/core/bfa_back.sv
`timescale 1ns / 1ps

module bfa_back #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [bfa_pkg::cnt_w(MAX_FRAMES)-1:0] eff_total,
	input  logic [bfa_pkg::cnt_w(MAX_FRAMES)-1:0] res_limit,
	input  bfa_pkg::queue_status_t                qstat,
	input  bfa_pkg::cmd_t                         q_cmd,
	output logic                                  q_pop,
	output bfa_pkg::back_status_t                 bstat,
	output logic                                  done,
	output logic [bfa_pkg::ADDR_W-1:0]            frame_address,
	output logic [bfa_pkg::STAT_W-1:0]            status
);

	localparam int CW         = bfa_pkg::cnt_w(MAX_FRAMES);
	localparam int WAW        = bfa_pkg::word_aw(MAX_FRAMES);
	localparam int WORD_COUNT = (MAX_FRAMES + 31) / 32;
	localparam int AW         = bfa_pkg::ADDR_W;
	localparam logic [WAW-1:0] LAST = WAW'(WORD_COUNT - 1);

	bfa_pkg::back_state_t state_q, state_d;

	logic [31:0]  mem [0:WORD_COUNT-1];
	logic [31:0]  rdata_s1;
	logic [WAW-1:0] widx_s1;
	logic         vld_s1;
	logic [WAW-1:0] ptr_q;
	logic [CW-1:0]  fidx_q;
	logic [WAW-1:0] fword;

	logic           mem_we;
	logic [WAW-1:0] mem_wa;
	logic [31:0]    mem_wd;
	logic [WAW-1:0] rd_addr;

	logic              res_valid;
	logic [AW-1:0]     res_addr;
	logic [bfa_pkg::STAT_W-1:0] res_status;
	logic              done_q;
	logic [AW-1:0]     faddr_q;
	logic [bfa_pkg::STAT_W-1:0] status_q;

	logic [CW-1:0]  sweep_base;
	logic [CW-1:0]  sweep_lim;
	logic           sweep_last;
	logic [CW-1:0]  scan_base;
	logic           past_end;
	logic           word_full;
	logic [31:0]    zero_oh;
	logic [4:0]     zero_pos;
	logic [CW-1:0]  aidx;
	logic           idx_bad;
	logic           scan_eval;
	logic           scan_fail;
	logic           scan_hit;
	logic [AW+CW-1:0] ashift;

	function automatic logic [31:0] init_word(input logic [CW-1:0] base,
	                                          input logic [CW-1:0] lim);
		logic [CW-1:0] diff;
		diff = lim - base;
		if (lim >= base + CW'(32)) begin
			return 32'hFFFF_FFFF;
		end else if (lim > base) begin
			return ~(32'hFFFF_FFFF << diff[4:0]);
		end else begin
			return 32'h0;
		end
	endfunction

	function automatic logic [4:0] onehot_pos(input logic [31:0] oh);
		logic [4:0] pos;
		pos = '0;
		for (int j = 0; j < 32; j++) begin
			if (oh[j]) begin
				pos = pos | 5'(j);
			end
		end
		return pos;
	endfunction

	assign bstat.clearing = (state_q == bfa_pkg::B_CLEAR);

	// init and the clearing pass share one sweep; clearing reserves nothing
	assign sweep_base = CW'({ptr_q, 5'b0});
	assign sweep_lim  = (state_q == bfa_pkg::B_CLEAR) ? '0 : res_limit;
	assign sweep_last = (ptr_q == LAST);

	assign scan_base = CW'({widx_s1, 5'b0});
	assign past_end  = scan_base >= eff_total;
	assign word_full = &rdata_s1;
	assign zero_oh   = ~rdata_s1 & (rdata_s1 + 32'd1);
	assign zero_pos  = onehot_pos(zero_oh);
	assign aidx      = CW'({widx_s1, zero_pos});
	assign idx_bad   = aidx >= eff_total;
	assign ashift    = {{AW{1'b0}}, aidx} << FRAME_SHIFT;

	assign scan_eval = (state_q == bfa_pkg::B_ALLOC) && vld_s1;
	assign scan_fail = scan_eval && (past_end || (word_full && widx_s1 == LAST) ||
	                                 (!word_full && idx_bad));
	assign scan_hit  = scan_eval && !past_end && !word_full && !idx_bad;

	assign fword = fidx_q[WAW+4:5];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfa_pkg::B_CLEAR: begin
				if (sweep_last) state_d = bfa_pkg::B_IDLE;
			end
			bfa_pkg::B_IDLE: begin
				if (qstat.valid) begin
					case (q_cmd.kind)
						bfa_pkg::CMD_INIT:  state_d = bfa_pkg::B_INIT;
						bfa_pkg::CMD_ALLOC: state_d = bfa_pkg::B_ALLOC;
						bfa_pkg::CMD_FREE:  state_d = bfa_pkg::B_FREE_RD;
						default:            state_d = bfa_pkg::B_IDLE;
					endcase
				end
			end
			bfa_pkg::B_INIT: begin
				if (sweep_last) state_d = bfa_pkg::B_IDLE;
			end
			bfa_pkg::B_ALLOC: begin
				if (scan_fail || scan_hit) state_d = bfa_pkg::B_IDLE;
			end
			bfa_pkg::B_FREE_RD: state_d = bfa_pkg::B_FREE_WR;
			bfa_pkg::B_FREE_WR: state_d = bfa_pkg::B_IDLE;
			default:            state_d = bfa_pkg::B_CLEAR;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = ptr_q;
		mem_wd     = init_word(sweep_base, sweep_lim);
		rd_addr    = ptr_q;
		res_valid  = 1'b0;
		res_addr   = '0;
		res_status = bfa_pkg::ST_DONE;
		unique case (state_q)
			bfa_pkg::B_CLEAR: begin
				mem_we = 1'b1;
			end
			bfa_pkg::B_IDLE: begin
				q_pop = qstat.valid;
				if (qstat.valid) begin
					case (q_cmd.kind)
						bfa_pkg::CMD_RANGE: begin
							res_valid  = 1'b1;
							res_status = bfa_pkg::ST_RANGE;
						end
						bfa_pkg::CMD_NOP: res_valid = 1'b1;
						default:          res_valid = 1'b0;
					endcase
				end
			end
			bfa_pkg::B_INIT: begin
				mem_we    = 1'b1;
				res_valid = sweep_last;
			end
			bfa_pkg::B_ALLOC: begin
				mem_wa = widx_s1;
				mem_wd = rdata_s1 | zero_oh;
				mem_we = scan_hit;
				if (scan_hit) begin
					res_valid = 1'b1;
					res_addr  = ashift[AW-1:0];
				end else if (scan_fail) begin
					res_valid  = 1'b1;
					res_status = bfa_pkg::ST_FULL;
				end
			end
			bfa_pkg::B_FREE_RD: begin
				rd_addr = fword;
			end
			bfa_pkg::B_FREE_WR: begin
				mem_we    = 1'b1;
				mem_wa    = fword;
				mem_wd    = rdata_s1 & ~(32'h1 << fidx_q[4:0]);
				res_valid = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::B_CLEAR;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == bfa_pkg::B_ALLOC);
			done_q  <= res_valid;
			if (q_pop) begin
				ptr_q <= '0;
			end else if ((state_q == bfa_pkg::B_CLEAR || state_q == bfa_pkg::B_INIT ||
			              state_q == bfa_pkg::B_ALLOC) && !sweep_last) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			faddr_q  <= res_addr;
			status_q <= res_status;
		end
		if (q_pop) begin
			fidx_q <= CW'(q_cmd.addr >> FRAME_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// one word read per cycle; data is registered and lands in the next cycle with its index
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		widx_s1  <= rd_addr;
	end

	assign done          = done_q;
	assign frame_address = faddr_q;
	assign status        = status_q;

endmodule

FILE: rtl/core/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// steps to the done strobe: an out-of-range free or unknown op is answered from idle, a free
// reads then writes back its bitmap word, an alloc reads bitmap words (one word per cycle
// through the single read port), init writes all WORD_COUNT words (one written per cycle).
// a new item starts once the previous one ends; two more wait in the command queue.
// after reset a clearing pass writes all WORD_COUNT words (1024 by default) with busy high.
// results are shown for one cycle and cannot be held off by the receiver.

module bitmap_frame_allocator #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [bfa_pkg::OP_W-1:0]         opcode,
	input  logic [bfa_pkg::ADDR_W-1:0]       free_address,
	output logic                             done,
	output logic [bfa_pkg::ADDR_W-1:0]       frame_address,
	output logic [bfa_pkg::STAT_W-1:0]       status,
	input  logic                             cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfa_pkg::CFG_W-1:0]        cfg_data
);

	localparam int CW = bfa_pkg::cnt_w(MAX_FRAMES);
	localparam logic [CW-1:0] CAP = CW'(MAX_FRAMES);

	logic [bfa_pkg::CFG_W-1:0] total_q;
	logic [bfa_pkg::CFG_W-1:0] reserved_q;
	logic [CW-1:0]             eff_total;
	logic [CW-1:0]             res_limit;

	bfa_pkg::queue_status_t qstat;
	bfa_pkg::back_status_t  bstat;
	bfa_pkg::cmd_t          push_cmd;
	bfa_pkg::cmd_t          head_cmd;
	logic                   q_push;
	logic                   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= bfa_pkg::TOTAL_RST;
			reserved_q <= bfa_pkg::RESERVED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfa_pkg::REG_TOTAL:    total_q    <= cfg_data;
				bfa_pkg::REG_RESERVED: reserved_q <= cfg_data;
				default:               total_q    <= total_q;
			endcase
		end
	end

	// counts above capacity saturate at the bitmap size
	assign eff_total = (CW'(total_q) > CAP) ? CAP : CW'(total_q);
	assign res_limit = (CW'(reserved_q) > CAP) ? CAP : CW'(reserved_q);

	bfa_front #(
		.MAX_FRAMES  (MAX_FRAMES),
		.FRAME_SHIFT (FRAME_SHIFT)
	) u_front (
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.free_address (free_address),
		.eff_total    (eff_total),
		.qstat        (qstat),
		.bstat        (bstat),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	bfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_cmd),
		.pop    (q_pop),
		.dout   (head_cmd),
		.qstat  (qstat)
	);

	bfa_back #(
		.MAX_FRAMES  (MAX_FRAMES),
		.FRAME_SHIFT (FRAME_SHIFT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.eff_total     (eff_total),
		.res_limit     (res_limit),
		.qstat         (qstat),
		.q_cmd         (head_cmd),
		.q_pop         (q_pop),
		.bstat         (bstat),
		.done          (done),
		.frame_address (frame_address),
		.status        (status)
	);

endmodule

FILE: rtl/core/bfa_checker.sv
`timescale 1ns / 1ps

module bfa_checker #(
	parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       busy,
	input logic                       done,
	input logic [bfa_pkg::ADDR_W-1:0] frame_address,
	input logic [bfa_pkg::STAT_W-1:0] status
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == bfa_pkg::ST_DONE || status == bfa_pkg::ST_FULL ||
		          status == bfa_pkg::ST_RANGE))
		else $error("result with an undefined status code");

	a_error_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bfa_pkg::ST_DONE) |-> (frame_address == '0))
		else $error("failed item returned a nonzero address");

	a_addr_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bfa_pkg::ST_DONE) |-> (frame_address[FRAME_SHIFT-1:0] == '0))
		else $error("frame address not aligned to a frame");

	a_clear_busy: assert property (@(posedge clk)
		(arst_n && !$past(arst_n)) |-> busy)
		else $error("item could be taken before the clearing pass");

endmodule

bind bitmap_frame_allocator bfa_checker #(.FRAME_SHIFT(FRAME_SHIFT)) u_bfa_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int MAXF  = bfa_pkg::MAX_FRAMES_DEF;
	localparam int WORDS = (bfa_pkg::MAX_FRAMES_DEF + 31) / 32;
	localparam int FSH   = bfa_pkg::FRAME_SHIFT_DEF;
	// opcode 3 has no meaning in the block
	localparam logic [bfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [bfa_pkg::ADDR_W-1:0] addr;
		logic [bfa_pkg::STAT_W-1:0] status;
	} alloc_answer_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [bfa_pkg::OP_W-1:0]      opcode = '0;
	logic [bfa_pkg::ADDR_W-1:0]    free_address = '0;
	logic                          cfg_we = 1'b0;
	logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bfa_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          busy;
	logic                          done;
	logic [bfa_pkg::ADDR_W-1:0]    frame_address;
	logic [bfa_pkg::STAT_W-1:0]    status;

	bitmap_frame_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.free_address (free_address),
		.done         (done),
		.frame_address(frame_address),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow copy of the allocator
	logic [31:0]   used_map [WORDS];
	int unsigned   cfg_total = bfa_pkg::TOTAL_RST;
	int unsigned   cfg_reserved = bfa_pkg::RESERVED_RST;
	alloc_answer_t frame_answers [$];
	int unsigned   held_frames [$];
	int            err_count = 0;
	int            burst_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		foreach (used_map[i]) used_map[i] = '0;
	end

	function automatic int unsigned managed_frames();
		return (cfg_total > MAXF) ? MAXF : cfg_total;
	endfunction

	function automatic void drop_held(int unsigned idx);
		int k;
		k = 0;
		while (k < held_frames.size()) begin
			if (held_frames[k] == idx)
				held_frames.delete(k);
			else
				k++;
		end
	endfunction

	function automatic void model_command(logic [bfa_pkg::OP_W-1:0] op,
	                                      logic [bfa_pkg::ADDR_W-1:0] addr);
		alloc_answer_t ans;
		int unsigned   idx, lim, total;
		int            w, b;
		logic          searching, found;
		ans.addr   = '0;
		ans.status = bfa_pkg::ST_DONE;
		total      = managed_frames();
		case (op)
			bfa_pkg::OP_INIT: begin
				lim = (cfg_reserved > MAXF) ? MAXF : cfg_reserved;
				for (w = 0; w < WORDS; w++)
					used_map[w] = '0;
				for (idx = 0; idx < lim; idx++)
					used_map[idx >> 5][idx & 31] = 1'b1;
				held_frames.delete();
			end
			bfa_pkg::OP_ALLOC: begin
				searching = 1'b1;
				found     = 1'b0;
				idx       = 0;
				for (w = 0; w < WORDS && searching; w++) begin
					if (w * 32 >= total)
						searching = 1'b0;
					else if (used_map[w] != 32'hFFFF_FFFF) begin
						for (b = 0; b < 32 && searching; b++) begin
							idx = w * 32 + b;
							if (idx >= total)
								searching = 1'b0;
							else if (!used_map[w][b]) begin
								used_map[w][b] = 1'b1;
								found          = 1'b1;
								searching      = 1'b0;
							end
						end
					end
				end
				if (found) begin
					ans.addr = bfa_pkg::ADDR_W'(idx << FSH);
					held_frames.push_back(idx);
				end else
					ans.status = bfa_pkg::ST_FULL;
			end
			bfa_pkg::OP_FREE: begin
				idx = addr >> FSH;
				if (idx >= total)
					ans.status = bfa_pkg::ST_RANGE;
				else begin
					used_map[idx >> 5][idx & 31] = 1'b0;
					drop_held(idx);
				end
			end
			default: ;
		endcase
		frame_answers.push_back(ans);
	endfunction

	// entered right after a rising edge, returns at the edge that took the item
	task automatic send_command(logic [bfa_pkg::OP_W-1:0] op,
	                            logic [bfa_pkg::ADDR_W-1:0] addr);
		logic taken;
		start        <= 1'b1;
		opcode       <= op;
		free_address <= addr;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		model_command(op, addr);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (frame_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int unsigned total, int unsigned reserved);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= bfa_pkg::REG_TOTAL;
		cfg_data  <= bfa_pkg::CFG_W'(total);
		@(posedge clk);
		cfg_index <= bfa_pkg::REG_RESERVED;
		cfg_data  <= bfa_pkg::CFG_W'(reserved);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_total    = total & 16'hFFFF;
		cfg_reserved = reserved & 16'hFFFF;
	endtask

	// bursts of items with random gaps in between
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	function automatic logic [bfa_pkg::ADDR_W-1:0] pick_free_address();
		int unsigned sel, total;
		logic [FSH-1:0] offs;
		sel   = $urandom_range(0, 99);
		total = managed_frames();
		offs  = FSH'($urandom);
		if (sel < 60 && held_frames.size() != 0)
			return bfa_pkg::ADDR_W'((held_frames[$urandom_range(0, held_frames.size() - 1)]
				<< FSH) | offs);
		else if (sel < 85 && total != 0)
			return bfa_pkg::ADDR_W'(($urandom_range(0, total - 1) << FSH) | offs);
		return bfa_pkg::ADDR_W'($urandom);
	endfunction

	task automatic test_before_init();
		// bitmap still all free after the clearing pass
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_FREE, 27'h0001ABC);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(OP_UNUSED, '1);
	endtask

	task automatic test_init_defaults();
		send_command(bfa_pkg::OP_INIT, '1);
		send_command(bfa_pkg::OP_ALLOC, '0);
		// frame that is already free
		send_command(bfa_pkg::OP_FREE, '1);
		send_command(bfa_pkg::OP_FREE, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
	endtask

	task automatic test_config_limits();
		set_config(0, 0);
		send_command(bfa_pkg::OP_INIT, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_FREE, '0);
		// both values past capacity, clamped
		set_config(16'hFFFF, 16'hFFFF);
		send_command(bfa_pkg::OP_INIT, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_FREE, '1);
		send_command(bfa_pkg::OP_ALLOC, '0);
	endtask

	task automatic test_padding_bits();
		set_config(3, 1);
		send_command(bfa_pkg::OP_INIT, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_ALLOC, '0);
		send_command(bfa_pkg::OP_FREE, 27'h0003000);
	endtask

	task automatic test_random_traffic();
		int unsigned total, reserved, sel;
		for (int p = 0; p < 16; p++) begin
			case (p)
				0: begin total = 16'hFFFF; reserved = 0; end
				1: begin total = $urandom_range(32700, 32768); reserved = 16'hFFFF; end
				2: begin total = 32; reserved = 32; end
				3: begin total = 32768; reserved = $urandom_range(0, 512); end
				default: begin
					total    = $urandom_range(1, 320);
					reserved = $urandom_range(0, total + 40);
				end
			endcase
			set_config(total, reserved);
			burst_left = 0;
			send_command(bfa_pkg::OP_INIT, bfa_pkg::ADDR_W'($urandom));
			for (int n = 0; n < 100; n++) begin
				pace_sender();
				if ($urandom_range(0, 99) == 0)
					wait_idle();
				sel = $urandom_range(0, 99);
				if (sel < 48)
					send_command(bfa_pkg::OP_ALLOC, bfa_pkg::ADDR_W'($urandom));
				else if (sel < 92)
					send_command(bfa_pkg::OP_FREE, pick_free_address());
				else if (sel < 97)
					send_command(OP_UNUSED, bfa_pkg::ADDR_W'($urandom));
				else
					send_command(bfa_pkg::OP_INIT, bfa_pkg::ADDR_W'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		alloc_answer_t exp_ans;
		if (arst_n && done) begin
			if (frame_answers.size() == 0) begin
				$display("%0t: result with nothing expected, frame_address %h status %0d",
					$time, frame_address, status);
				err_count++;
			end else begin
				exp_ans = frame_answers.pop_front();
				if (frame_address !== exp_ans.addr) begin
					$display("%0t: frame_address expected %h actual %h",
						$time, exp_ans.addr, frame_address);
					err_count++;
				end
				if (status !== exp_ans.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_ans.status, status);
					err_count++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_init();
		test_init_defaults();
		test_config_limits();
		test_padding_bits();
		test_random_traffic();
		wait_idle();
		repeat (1100) @(posedge clk);
		if (err_count == 0 && frame_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_queue.sv
rtl/core/bfa_front.sv
rtl/core/bfa_back.sv
rtl/core/bitmap_frame_allocator.sv
rtl/core/bfa_checker.sv
verif/tb.sv
